// ===== hdl/itb_pkg.sv =====
package itb_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam logic [30:0] OVR_MAX = 31'h7fffffff;
   localparam logic [63:0] U64_MAX = 64'hffffffffffffffff;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_SETTIME = 3'd2;
   localparam logic [2:0] REQ_GETTIME = 3'd3;
   localparam logic [2:0] REQ_TICK = 3'd4;
   localparam logic [2:0] REQ_STOP = 3'd5;
   localparam logic [2:0] REQ_START = 3'd6;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD_SLOT = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [4:0]  timer_index;
      logic        abs_time;
      logic [63:0] new_value;
      logic [63:0] new_interval;
      logic [63:0] current_time;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  slot_index;
      logic        fired;
      logic [30:0] overruns;
      logic [63:0] remaining;
      logic [63:0] interval;
      logic        last;
   } rsp_word_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? U64_MAX : s[63:0];
   endfunction

endpackage

// ===== hdl/itb_divider.sv =====
// Restoring divider, one quotient bit per cycle: q = n / d, r = n % d.
module itb_divider
   import itb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] numer,
   input  logic [63:0] denom,
   output logic        done,
   output logic [63:0] quot,
   output logic [63:0] rem
);
   logic [63:0] q_ff, q_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = 7'd64;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[62:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem = r_ff;
endmodule

// ===== hdl/interval_timer_bank.sv =====
// channel   dir  handshake              word
// request   in   start & !busy          req_word (req_word_type)
// response  out  rsp_valid, one cycle   rsp_word (rsp_word_type)
//
// Every request but tick passes read, execute, done; word registered in execute.
// Tick walks all slots (read, next if skipped; read, execute, next if checked), plus
// a divide wait per late periodic timer (64-step divider); last word after the walk.
// Synchronous reset clears control, valid, stop bits and fills the free list (flops);
// memory words are written on create before they are ever read.
// The receiver cannot stall; busy holds off new requests.
module interval_timer_bank
   import itb_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0] NONE = LW'(SLOTS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_NEXT = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // expiry and period memories, one read port each, registered read
   logic [63:0] exp_mem [SLOTS];
   logic [63:0] per_mem [SLOTS];
   logic [63:0] exp_rd_ff, per_rd_ff;
   logic [IW-1:0] rd_addr;
   logic        wr_exp, wr_per;
   logic [IW-1:0] wr_addr;
   logic [63:0] wr_exp_data, wr_per_data;

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] stop_ff, stop_in;
   logic [LW-1:0] link_ff [SLOTS];
   logic [LW-1:0] link_in [SLOTS];
   logic [LW-1:0] head_ff, head_in;

   logic [2:0]   state_ff, state_in;
   req_word_type req_ff, req_in;
   logic [IW:0]  scan_ff, scan_in;
   logic         any_ff, any_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;
   rsp_word_type pend_ff, pend_in;
   logic         pend_ff_v, pend_in_v;

   logic        div_start, div_done;
   logic [63:0] div_q;
   logic [63:0] div_r;
   logic [63:0] late_d;
   logic [IW-1:0] cur;
   logic [IW-1:0] idx;
   logic        idx_ok;

   itb_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(late_d - 64'd1), .denom(per_rd_ff),
      .done(div_done), .quot(div_q), .rem(div_r)
   );

   assign cur = scan_ff[IW-1:0];
   assign idx = req_ff.timer_index[IW-1:0];
   assign idx_ok = ({27'd0, req_ff.timer_index} < 32'(SLOTS)) && valid_ff[idx];
   assign late_d = req_ff.current_time - exp_rd_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      scan_in = scan_ff;
      any_in = any_ff;
      valid_in = valid_ff;
      stop_in = stop_ff;
      link_in = link_ff;
      head_in = head_ff;
      out_valid_in = 1'b0;
      out_in = out_ff;
      pend_in = pend_ff;
      pend_in_v = pend_ff_v;
      rd_addr = cur;
      wr_exp = 1'b0;
      wr_per = 1'b0;
      wr_addr = cur;
      wr_exp_data = '0;
      wr_per_data = '0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_word;
               scan_in = '0;
               any_in = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // issue memory read for addressed slot or scan slot
            rd_addr = (req_ff.req_type == REQ_TICK) ? cur : idx;
            state_in = S_EXEC;
            if (req_ff.req_type == REQ_TICK && !(valid_ff[cur] && !stop_ff[cur]))
               state_in = S_NEXT;
         end
         S_EXEC: begin
            out_in = '0;
            out_in.last = 1'b1;
            state_in = S_DONE;
            case (req_ff.req_type)
               REQ_CREATE: begin
                  if (head_ff == NONE) begin
                     out_in.status = ST_FULL;
                  end else begin
                     head_in = link_ff[head_ff[IW-1:0]];
                     valid_in[head_ff[IW-1:0]] = 1'b1;
                     stop_in[head_ff[IW-1:0]] = 1'b0;
                     wr_exp = 1'b1;
                     wr_per = 1'b1;
                     wr_addr = head_ff[IW-1:0];
                     out_in.slot_index = 5'(head_ff);
                  end
                  out_valid_in = 1'b1;
               end
               REQ_DELETE: begin
                  if (!idx_ok) begin
                     out_in.status = ST_BAD_SLOT;
                  end else begin
                     valid_in[idx] = 1'b0;
                     stop_in[idx] = 1'b0;
                     link_in[idx] = head_ff;
                     head_in = LW'(idx);
                  end
                  out_valid_in = 1'b1;
               end
               REQ_SETTIME, REQ_GETTIME: begin
                  if (!idx_ok) begin
                     out_in.status = ST_BAD_SLOT;
                  end else begin
                     out_in.remaining = (exp_rd_ff > req_ff.current_time) ?
                        exp_rd_ff - req_ff.current_time : 64'd0;
                     out_in.interval = per_rd_ff;
                     if (req_ff.req_type == REQ_SETTIME) begin
                        wr_exp = 1'b1;
                        wr_per = 1'b1;
                        wr_addr = idx;
                        wr_per_data = req_ff.new_interval;
                        wr_exp_data = req_ff.new_value;
                        if (req_ff.new_value != 64'd0) begin
                           if (!req_ff.abs_time)
                              wr_exp_data = sat_add(req_ff.new_value, req_ff.current_time);
                           else if (req_ff.new_value < req_ff.current_time)
                              wr_exp_data = req_ff.current_time;
                        end
                     end
                  end
                  out_valid_in = 1'b1;
               end
               REQ_TICK: begin
                  state_in = S_NEXT;
                  if (exp_rd_ff != 64'd0 && exp_rd_ff <= req_ff.current_time) begin
                     // emit previously held fire, hold this one
                     out_in = pend_ff;
                     out_valid_in = pend_ff_v;
                     pend_in_v = 1'b1;
                     any_in = 1'b1;
                     pend_in = '0;
                     pend_in.slot_index = 5'(cur);
                     pend_in.fired = 1'b1;
                     pend_in.interval = per_rd_ff;
                     wr_exp = 1'b1;
                     wr_addr = cur;
                     if (exp_rd_ff == req_ff.current_time) begin
                        wr_exp_data = (per_rd_ff != 0) ? sat_add(exp_rd_ff, per_rd_ff) : 64'd0;
                     end else if (per_rd_ff == 64'd0) begin
                        wr_exp_data = '0;
                        pend_in.overruns = 31'd1;
                     end else begin
                        wr_exp = 1'b0;
                        div_start = 1'b1;
                        state_in = S_DIV;
                     end
                  end
               end
               REQ_STOP, REQ_START: begin
                  for (int i = 0; i < SLOTS; i++)
                     if (valid_ff[i]) stop_in[i] = (req_ff.req_type == REQ_STOP);
                  out_valid_in = 1'b1;
               end
               default: begin
                  out_in.status = ST_BAD_SLOT;
                  out_valid_in = 1'b1;
               end
            endcase
         end
         S_DIV: begin
            // e + q*p = now - 1 - r, so the remainder gives the new expiry
            if (div_done) begin
               wr_exp = 1'b1;
               wr_addr = cur;
               wr_exp_data = sat_add(req_ff.current_time - 64'd1 - div_r, per_rd_ff);
               pend_in.overruns = (div_q >= 64'(OVR_MAX)) ? OVR_MAX : 31'(div_q + 64'd1);
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            scan_in = scan_ff + 1'b1;
            state_in = S_READ;
            if (scan_ff == (IW+1)'(SLOTS - 1)) begin
               out_in = pend_ff;
               out_in.last = 1'b1;
               if (!any_ff) begin
                  out_in = '0;
                  out_in.last = 1'b1;
               end
               out_valid_in = 1'b1;
               pend_in_v = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_exp) exp_mem[wr_addr] <= wr_exp_data;
      if (wr_per) per_mem[wr_addr] <= wr_per_data;
      exp_rd_ff <= exp_mem[rd_addr];
      per_rd_ff <= per_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         stop_ff <= '0;
         head_ff <= '0;
         for (int i = 0; i < SLOTS; i++) link_ff[i] <= LW'(i + 1);
         out_valid_ff <= 1'b0;
         pend_ff_v <= 1'b0;
         any_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         stop_ff <= stop_in;
         head_ff <= head_in;
         link_ff <= link_in;
         out_valid_ff <= out_valid_in;
         pend_ff_v <= pend_in_v;
         any_ff <= any_in;
         scan_ff <= scan_in;
      end
      req_ff <= req_in;
      out_ff <= out_in;
      pend_ff <= pend_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NONE) else $error("free head out of range");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done outside wait");
`endif
endmodule
